/* hw/rtl/vsti_pkg.sv */
// vsti_pkg: shared constants, codes and types for the video scan timing core.
// No dependencies; used by vsti_step, vsti_out_stage and video_scan_timing_irq_core.
`timescale 1ns / 1ps
`default_nettype none
package vsti_pkg;

    localparam int H_W   = 11;
    localparam int V_W   = 9;
    localparam int FRM_W = 16;
    localparam int EVT_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [H_W-1:0] LINE_CYCLES  = 11'd1374;
    localparam logic [H_W-1:0] HBLANK_AT    = 11'd274;
    localparam logic [V_W-1:0] ACTIVE_LINES = 9'd224;
    localparam logic [V_W-1:0] FRAME_LINES  = 9'd262;
    localparam logic [V_W-1:0] VBLANK_LINE  = 9'd225;
    localparam logic [V_W-1:0] CTRL_LINE    = 9'd227;

    // irq_mode codes
    localparam logic [1:0] IRQ_NONE = 2'd0;
    localparam logic [1:0] IRQ_H    = 2'd1;
    localparam logic [1:0] IRQ_V    = 2'd2;
    localparam logic [1:0] IRQ_HV   = 2'd3;

    // mid-line event codes
    localparam logic [EVT_W-1:0] MID_NONE   = 2'd0;
    localparam logic [EVT_W-1:0] MID_HDMA   = 2'd1;
    localparam logic [EVT_W-1:0] MID_RENDER = 2'd2;
    localparam logic [EVT_W-1:0] MID_DISP_END = 2'd3;

    // line-end event codes
    localparam logic [EVT_W-1:0] LEND_NONE   = 2'd0;
    localparam logic [EVT_W-1:0] LEND_VBLANK = 2'd1;
    localparam logic [EVT_W-1:0] LEND_PAD    = 2'd2;
    localparam logic [EVT_W-1:0] LEND_FRAME  = 2'd3;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_H_MATCH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_V_MATCH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NMI_ENABLE = 2'd3;

    typedef struct packed {
        logic [1:0]     irq_mode;
        logic [H_W-1:0] h_match;
        logic [V_W-1:0] v_match;
        logic           nmi_enable;
    } t_cfg;

    typedef struct packed {
        logic [H_W-1:0]   h_position;
        logic [V_W-1:0]   line_number;
        logic             in_h_blank;
        logic             in_v_blank;
        logic             odd_field;
        logic [FRM_W-1:0] frames_done;
        logic             nmi_request;
        logic             irq_request;
    } t_state;

    typedef struct packed {
        logic advance;
        logic nmi_taken;
        logic irq_taken;
    } t_tick;

    typedef struct packed {
        t_state           st;
        logic [EVT_W-1:0] mid_line_event;
        logic [EVT_W-1:0] line_end_event;
    } t_result;

endpackage
`default_nettype wire

/* hw/rtl/vsti_in_if.sv */
// vsti_in_if: valid/ready channel carrying one tick word.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface vsti_in_if;
    logic valid;
    logic ready;
    logic advance;
    logic nmi_taken;
    logic irq_taken;

    modport source (output valid, output advance, output nmi_taken, output irq_taken,
                    input ready);
    modport sink   (input valid, input advance, input nmi_taken, input irq_taken,
                    output ready);
endinterface
`default_nettype wire

/* hw/rtl/vsti_out_if.sv */
// vsti_out_if: valid/ready channel carrying one timing status word.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface vsti_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] h_count;
    logic [8:0]  v_count;
    logic        h_blank;
    logic        v_blank;
    logic        field;
    logic [15:0] frame_count;
    logic        nmi_pending;
    logic        irq_pending;
    logic [1:0]  mid_line_event;
    logic [1:0]  line_end_event;

    modport source (output valid, output h_count, output v_count, output h_blank,
                    output v_blank, output field, output frame_count, output nmi_pending,
                    output irq_pending, output mid_line_event, output line_end_event,
                    input ready);
    modport sink   (input valid, input h_count, input v_count, input h_blank,
                    input v_blank, input field, input frame_count, input nmi_pending,
                    input irq_pending, input mid_line_event, input line_end_event,
                    output ready);
endinterface
`default_nettype wire

/* hw/rtl/vsti_step.sv */
// vsti_step: next raster/interrupt state and line events for one tick.
// Depends on vsti_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vsti_step (
    input  var vsti_pkg::t_state  i_state,
    input  var vsti_pkg::t_cfg    i_cfg,
    input  var vsti_pkg::t_tick   i_tick,
    output var vsti_pkg::t_result o_result
);
    vsti_pkg::t_state                 st;
    logic [vsti_pkg::H_W-1:0]         h_inc;
    logic [vsti_pkg::V_W-1:0]         v_inc;
    logic [vsti_pkg::EVT_W-1:0]       mid;
    logic [vsti_pkg::EVT_W-1:0]       lend;

    assign h_inc = i_state.h_position + vsti_pkg::H_W'(1);
    assign v_inc = i_state.line_number + vsti_pkg::V_W'(1);

    always_comb begin
        st   = i_state;
        mid  = vsti_pkg::MID_NONE;
        lend = vsti_pkg::LEND_NONE;
        // acknowledges act before any raise in the same tick
        if (i_tick.nmi_taken) begin
            st.nmi_request = 1'b0;
        end
        if (i_tick.irq_taken) begin
            st.irq_request = 1'b0;
        end
        if (i_tick.advance) begin
            st.h_position = h_inc;
            if (h_inc == vsti_pkg::HBLANK_AT) begin
                if (i_state.line_number == vsti_pkg::ACTIVE_LINES) begin
                    mid = vsti_pkg::MID_DISP_END;
                end else if (i_state.line_number > vsti_pkg::ACTIVE_LINES) begin
                    mid = vsti_pkg::MID_NONE;
                end else if (i_state.line_number != '0) begin
                    mid = vsti_pkg::MID_RENDER;
                end else begin
                    mid = vsti_pkg::MID_HDMA;
                end
                st.in_h_blank = 1'b1;
            end else if (h_inc == vsti_pkg::LINE_CYCLES) begin
                st.h_position  = '0;
                st.in_h_blank  = 1'b0;
                st.line_number = v_inc;
                // V match sees the line before the frame wrap
                if (i_cfg.irq_mode == vsti_pkg::IRQ_V && i_cfg.v_match == v_inc) begin
                    st.irq_request = 1'b1;
                end
                if (v_inc == vsti_pkg::VBLANK_LINE) begin
                    st.in_v_blank = 1'b1;
                    if (i_cfg.nmi_enable) begin
                        st.nmi_request = 1'b1;
                    end
                    lend = vsti_pkg::LEND_VBLANK;
                end else if (v_inc == vsti_pkg::CTRL_LINE) begin
                    lend = vsti_pkg::LEND_PAD;
                end else if (v_inc == vsti_pkg::FRAME_LINES) begin
                    st.frames_done = i_state.frames_done + vsti_pkg::FRM_W'(1);
                    st.line_number = '0;
                    st.odd_field   = ~i_state.odd_field;
                    st.in_v_blank  = 1'b0;
                    lend = vsti_pkg::LEND_FRAME;
                end
            end
            if (i_cfg.h_match == st.h_position) begin
                if (i_cfg.irq_mode == vsti_pkg::IRQ_H ||
                    (i_cfg.irq_mode == vsti_pkg::IRQ_HV &&
                     i_cfg.v_match == st.line_number)) begin
                    st.irq_request = 1'b1;
                end
            end
        end
    end

    assign o_result.st             = st;
    assign o_result.mid_line_event = mid;
    assign o_result.line_end_event = lend;

endmodule
`default_nettype wire

/* hw/rtl/vsti_out_stage.sv */
// vsti_out_stage: result register between the step logic and the output channel.
// Depends on vsti_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vsti_out_stage (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_load,
    input  var vsti_pkg::t_result i_data,
    input  wire                   i_take,
    output logic                  o_free,
    output logic                  o_valid,
    output var vsti_pkg::t_result o_data
);
    logic              r_valid;
    vsti_pkg::t_result r_data;

    // free when empty or the held word leaves this cycle
    assign o_free  = ~r_valid | i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/video_scan_timing_irq_core.sv */
// video_scan_timing_irq_core: raster H/V counter with NMI/IRQ requests.
// A tick word's status word is registered and appears in the cycle after it is accepted.
// Throughput: one tick per cycle; the result register stalls input only
// while it holds a word the sink has not taken.
// Reset (synchronous, active low) clears counters, flags, requests and config.
// Depends on vsti_pkg, vsti_in_if, vsti_out_if, vsti_step, vsti_out_stage.
`timescale 1ns / 1ps
`default_nettype none
module video_scan_timing_irq_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [vsti_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [vsti_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    vsti_in_if.sink                             i_in,
    vsti_out_if.source                          o_out
);
    vsti_pkg::t_cfg    r_cfg;
    vsti_pkg::t_state  r_state;
    vsti_pkg::t_tick   tick;
    vsti_pkg::t_result n_result;
    vsti_pkg::t_result out_data;
    logic              out_free;
    logic              out_valid;
    logic              accept;

    assign tick.advance   = i_in.advance;
    assign tick.nmi_taken = i_in.nmi_taken;
    assign tick.irq_taken = i_in.irq_taken;

    assign i_in.ready = out_free;
    assign accept     = i_in.valid & out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vsti_pkg::CFG_IRQ_MODE:   r_cfg.irq_mode   <= i_cfg_data[1:0];
                vsti_pkg::CFG_H_MATCH:    r_cfg.h_match    <= i_cfg_data[10:0];
                vsti_pkg::CFG_V_MATCH:    r_cfg.v_match    <= i_cfg_data[8:0];
                vsti_pkg::CFG_NMI_ENABLE: r_cfg.nmi_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_result.st;
        end
    end

    vsti_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_tick   (tick),
        .o_result (n_result)
    );

    vsti_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_data  (n_result),
        .i_take  (o_out.ready),
        .o_free  (out_free),
        .o_valid (out_valid),
        .o_data  (out_data)
    );

    assign o_out.valid          = out_valid;
    assign o_out.h_count        = out_data.st.h_position;
    assign o_out.v_count        = out_data.st.line_number;
    assign o_out.h_blank        = out_data.st.in_h_blank;
    assign o_out.v_blank        = out_data.st.in_v_blank;
    assign o_out.field          = out_data.st.odd_field;
    assign o_out.frame_count    = out_data.st.frames_done;
    assign o_out.nmi_pending    = out_data.st.nmi_request;
    assign o_out.irq_pending    = out_data.st.irq_request;
    assign o_out.mid_line_event = out_data.mid_line_event;
    assign o_out.line_end_event = out_data.line_end_event;

endmodule
`default_nettype wire
